FILE: sv/stable_min_priority_queue_macros.svh
// assertion macros for the stable min priority queue
`ifndef STABLE_MIN_PRIORITY_QUEUE_MACROS_SVH
`define STABLE_MIN_PRIORITY_QUEUE_MACROS_SVH

// check a property on the rising clock edge, masked while reset is active
`define SPQ_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check a property on the rising clock edge, also during reset
`define SPQ_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: sv/spq_pkg.sv
// package with types and constants of the stable min priority queue
`default_nettype none
package spq_pkg;

    localparam int DEPTH      = 16;
    localparam int DATA_WIDTH = 32;
    localparam int PRIO_WIDTH = 8;
    localparam int CNT_W      = $clog2(DEPTH + 1);

    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_POP  = 1'b1;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_EMPTY = 2'd1;
    localparam logic [1:0] STATUS_FULL  = 2'd2;

    typedef struct packed {
        logic                  cmd;
        logic [DATA_WIDTH-1:0] in_data;
        logic [PRIO_WIDTH-1:0] in_priority;
    } req_t;

    typedef struct packed {
        logic [1:0]            status;
        logic [DATA_WIDTH-1:0] out_data;
        logic [CNT_W-1:0]      count;
        logic                  head_valid;
        logic [DATA_WIDTH-1:0] head_data;
    } rsp_t;

    typedef struct packed {
        logic [PRIO_WIDTH-1:0] prio;
        logic [DATA_WIDTH-1:0] data;
    } entry_t;

    typedef struct packed {
        logic insert;
        logic remove;
    } cell_ctrl_t;

endpackage
`default_nettype wire

FILE: sv/stable_min_priority_queue.sv
// top level of the stable min priority queue
// Bounded priority queue of spq_pkg::DEPTH entries kept as a chain of cells sorted by
// priority, ties in push order, so the head always sits in the first cell. Each request
// transaction is either a push or a pop and produces exactly one response transaction
// with status, popped word, count after the operation and the new head entry. Every cell
// updates to one of (keep, take the new entry, take the left neighbor on push,
// take the right neighbor on pop). The one-deep response register takes a new request
// in the same cycle that the previous response is taken, so requests follow back to
// back while the response side keeps ready high; while a response waits, req_ready is
// low. The registered response is valid in the cycle after acceptance. Pop on an empty
// queue and push on a full queue leave the contents untouched and report an error status.
`default_nettype none
module stable_min_priority_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_ready,
    input  spq_pkg::req_t  req,
    output logic           rsp_valid,
    input  logic           rsp_ready,
    output spq_pkg::rsp_t  rsp
);
    import spq_pkg::*;

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             rsp_valid_reg;
    logic             rsp_valid_next;
    rsp_t             rsp_reg;
    rsp_t             rsp_next;

    logic       accept;
    logic       empty;
    logic       full;
    logic       do_push;
    logic       do_pop;
    cell_ctrl_t ctrl;
    entry_t     new_entry;

    entry_t           cell_entry [DEPTH];
    logic [DEPTH-1:0] cell_keep;
    logic [DEPTH-1:0] cell_valid;

    // a waiting response never blocks the next request once it is being taken
    assign req_ready = !rsp_valid_reg || rsp_ready;
    assign accept    = req_valid && req_ready;

    assign empty   = (count_reg == '0);
    assign full    = (count_reg == CNT_W'(DEPTH));
    assign do_push = accept && (req.cmd == CMD_PUSH) && !full;
    assign do_pop  = accept && (req.cmd == CMD_POP) && !empty;

    assign ctrl.insert = do_push;
    assign ctrl.remove = do_pop;

    assign new_entry.prio = req.in_priority;
    assign new_entry.data = req.in_data;

    // sorted cell chain, the head in cell zero
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        entry_t left_entry;
        entry_t right_entry;
        logic   left_keep;

        assign cell_valid[i] = (count_reg > CNT_W'(i));

        if (i == 0)
        begin : g_first
            assign left_entry = new_entry;
            assign left_keep  = 1'b1;
        end
        else
        begin : g_inner
            assign left_entry = cell_entry[i-1];
            assign left_keep  = cell_keep[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign right_entry = cell_entry[i];
        end
        else
        begin : g_body
            assign right_entry = cell_entry[i+1];
        end

        spq_cell u_cell (
            .clk         (clk),
            .ctrl        (ctrl),
            .new_entry   (new_entry),
            .left_entry  (left_entry),
            .right_entry (right_entry),
            .valid       (cell_valid[i]),
            .left_keep   (left_keep),
            .entry       (cell_entry[i]),
            .keep        (cell_keep[i])
        );
    end

    always_comb
    begin
        count_next = count_reg;
        if (do_push)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    // response as it will look after this transaction
    always_comb
    begin
        rsp_next            = rsp_reg;
        rsp_next.status     = STATUS_OK;
        rsp_next.out_data   = '0;
        rsp_next.count      = count_next;
        rsp_next.head_valid = (count_next != '0);
        rsp_next.head_data  = '0;

        if (req.cmd == CMD_PUSH && full)
        begin
            rsp_next.status = STATUS_FULL;
        end
        if (req.cmd == CMD_POP && empty)
        begin
            rsp_next.status = STATUS_EMPTY;
        end
        if (do_pop)
        begin
            rsp_next.out_data = cell_entry[0].data;
        end

        if (count_next != '0)
        begin
            if (do_push)
            begin
                // equal priority keeps the older head
                if (empty || (new_entry.prio < cell_entry[0].prio))
                begin
                    rsp_next.head_data = new_entry.data;
                end
                else
                begin
                    rsp_next.head_data = cell_entry[0].data;
                end
            end
            else if (do_pop)
            begin
                rsp_next.head_data = cell_entry[1].data;
            end
            else
            begin
                rsp_next.head_data = cell_entry[0].data;
            end
        end
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (accept)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // response payload, loaded once per request transaction
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule
`default_nettype wire

FILE: sv/spq_cell.sv
// one cell of the sorted entry chain
`default_nettype none
module spq_cell (
    input  logic                clk,
    input  spq_pkg::cell_ctrl_t ctrl,
    input  spq_pkg::entry_t     new_entry,
    input  spq_pkg::entry_t     left_entry,
    input  spq_pkg::entry_t     right_entry,
    input  logic                valid,
    input  logic                left_keep,
    output spq_pkg::entry_t     entry,
    output logic                keep
);
    import spq_pkg::*;

    entry_t entry_reg;
    entry_t entry_next;

    // an entry stays put on insert when it is served no later than the new one
    assign keep = valid && (entry_reg.prio <= new_entry.prio);

    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.insert)
        begin
            if (!keep)
            begin
                entry_next = left_keep ? new_entry : left_entry;
            end
        end
        else if (ctrl.remove)
        begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule
`default_nettype wire

FILE: sv/spq_checker.sv
// port checker for the stable min priority queue and its bind
`default_nettype none
`include "stable_min_priority_queue_macros.svh"
module spq_checker (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    input  logic          req_ready,
    input  logic          rsp_valid,
    input  logic          rsp_ready,
    input  spq_pkg::rsp_t rsp
);
    import spq_pkg::*;

    `SPQ_ASSERT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp), "response changed while stalled")
    `SPQ_ASSERT(a_head_count, clk, rst_n, rsp_valid |-> (rsp.head_valid == (rsp.count != '0)), "head_valid disagrees with count")
    `SPQ_ASSERT(a_empty_err, clk, rst_n, rsp_valid && rsp.status == STATUS_EMPTY |-> rsp.count == '0 && rsp.out_data == '0, "empty pop with entries or data")
    `SPQ_ASSERT(a_full_err, clk, rst_n, rsp_valid && rsp.status == STATUS_FULL |-> rsp.count == CNT_W'(DEPTH), "full push below depth")
    `SPQ_ASSERT(a_count_step, clk, rst_n, req_valid && req_ready && rsp_valid && rsp_ready |=> rsp.count == $past(rsp.count) + CNT_W'(1) || rsp.count == $past(rsp.count) - CNT_W'(1) || rsp.count == $past(rsp.count), "count jumped by more than one")

endmodule

bind stable_min_priority_queue spq_checker u_spq_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
);
`default_nettype wire
